/* rtl/core/swpf_pkg.sv */
`default_nettype none

package swpf_pkg;

    localparam int MAX_HALF_WINDOW_DEF = 31;
    localparam int CHANNELS_DEF        = 4096;

    localparam int SAMPLE_W   = 32;
    localparam int HW_W       = 5;
    localparam int CH_W       = 12;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    // peak_channel + peak_height + overflow, rounded up to whole bytes
    localparam int OUT_DATA_W = 48;

    localparam logic [HW_W-1:0]     HW_RESET = 5'd23;
    localparam logic [SAMPLE_W-1:0] MH_RESET = 32'd20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_HALF_WINDOW = 1'b0,
        CFG_MIN_HEIGHT  = 1'b1
    } t_cfg_addr;

endpackage

`default_nettype wire

/* rtl/core/swpf_cell.sv */
`default_nettype none

// One window slot. Holds a count plus the distances to the nearest
// older and newer counts that are >= it (NONE when there is none yet).
module swpf_cell #(
    parameter  int MAX_HALF_WINDOW = swpf_pkg::MAX_HALF_WINDOW_DEF,
    parameter  int POS             = 0,
    localparam int DIST_W          = $clog2(MAX_HALF_WINDOW + 2)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_shift,
    input  wire logic                          i_clear,
    input  wire logic [swpf_pkg::SAMPLE_W-1:0] i_x,
    input  wire logic                          i_prev_valid,
    input  wire logic [swpf_pkg::SAMPLE_W-1:0] i_prev_sample,
    input  wire logic [DIST_W-1:0]             i_prev_left,
    input  wire logic [DIST_W-1:0]             i_prev_right,
    output logic                               o_ge,
    output logic                               o_valid,
    output logic [swpf_pkg::SAMPLE_W-1:0]      o_sample,
    output logic [DIST_W-1:0]                  o_left,
    output logic [DIST_W-1:0]                  o_right
);
    import swpf_pkg::*;

    localparam logic [DIST_W-1:0] DIST_NONE = DIST_W'(MAX_HALF_WINDOW + 1);
    // distance to the incoming sample once it has shifted in
    localparam logic [DIST_W-1:0] MY_DIST   = DIST_W'(POS + 1);

    logic                r_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic [DIST_W-1:0]   r_left;
    logic [DIST_W-1:0]   r_right;
    logic                le;

    assign o_ge     = r_valid && (r_sample >= i_x);
    assign le       = r_valid && (i_x >= r_sample);
    assign o_valid  = r_valid;
    assign o_sample = r_sample;
    assign o_left   = r_left;
    // first newer sample that reaches us is the nearest one
    assign o_right  = (le && (r_right == DIST_NONE)) ? MY_DIST : r_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_clear ? 1'b0 : i_prev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_prev_sample;
            r_left   <= i_prev_left;
            r_right  <= i_prev_right;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/spectrum_window_peak_finder.sv */
`default_nettype none

// A peak is registered into the output register or skid slot by the transaction that
//   settles it, i.e. the sample half_window channels later, or the end-of-spectrum sample.
// Throughput: one sample per cycle unless stalled; the whole comparator row shifts at once.
//   Input stalls only while both the output register and the skid slot hold a peak.
// Reset (synchronous, active low): window emptied, counters cleared,
//   half_window = 23, min_height = 20, output stages empty.
module spectrum_window_peak_finder #(
    parameter int MAX_HALF_WINDOW = swpf_pkg::MAX_HALF_WINDOW_DEF,
    parameter int CHANNELS        = swpf_pkg::CHANNELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // sample stream: tdata = sample_count[31:0]; tlast = end_of_spectrum
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [swpf_pkg::SAMPLE_W-1:0]   s_axis_tdata,
    input  wire logic                            s_axis_tlast,
    // peak stream: tdata = peak_channel[11:0], peak_height[43:12],
    //              overflow[44], zero pad [47:45]
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [swpf_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // config write port: 0 = half_window, 1 = min_height
    input  wire logic                            i_cfg_we,
    input  wire logic [swpf_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [swpf_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import swpf_pkg::*;

    localparam int DIST_W = $clog2(MAX_HALF_WINDOW + 2);
    localparam int AGE_W  = $clog2(MAX_HALF_WINDOW + 1);
    localparam int CNT_W  = $clog2(CHANNELS + 1);
    localparam logic [DIST_W-1:0] DIST_NONE = DIST_W'(MAX_HALF_WINDOW + 1);
    localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(CHANNELS);

    // Config
    logic [HW_W-1:0]     r_half_window;
    logic [SAMPLE_W-1:0] r_min_height;
    logic [DIST_W-1:0]   h;

    // Spectrum bookkeeping
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;
    logic [CNT_W-1:0] cnt_post;
    logic             ovf_post;

    // Output register plus skid slot
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_skid_valid;
    logic [OUT_DATA_W-1:0] r_skid_data;

    logic accept;
    logic push;

    // Window contents after this transaction, index = age (0 = newest).
    logic                       p_valid  [MAX_HALF_WINDOW+1];
    logic [SAMPLE_W-1:0]        p_sample [MAX_HALF_WINDOW+1];
    logic [DIST_W-1:0]          p_left   [MAX_HALF_WINDOW+1];
    logic [DIST_W-1:0]          p_right  [MAX_HALF_WINDOW+1];
    logic [MAX_HALF_WINDOW-1:0] ge;
    logic [MAX_HALF_WINDOW-1:0] ge_low;
    logic [DIST_W-1:0]          new_left;

    // Decision
    logic [MAX_HALF_WINDOW:0] cand;
    logic [SAMPLE_W-1:0]      sel_sample;
    logic [AGE_W-1:0]         sel_age;
    logic                     found;
    logic [CNT_W-1:0]         idx;
    logic [OUT_DATA_W-1:0]    res_data;

    assign s_axis_tready = !r_skid_valid;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign h = (int'(r_half_window) > MAX_HALF_WINDOW) ? DIST_W'(MAX_HALF_WINDOW)
                                                       : DIST_W'(r_half_window);

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= HW_RESET;
            r_min_height  <= MH_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_HALF_WINDOW: r_half_window <= i_cfg_wdata[HW_W-1:0];
                CFG_MIN_HEIGHT:  r_min_height  <= i_cfg_wdata[SAMPLE_W-1:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // New sample entering the window. Its left distance is the nearest
    // older count that is >= it: lowest set bit of the cells' ge flags.
    // ------------------------------------------------------------------
    always_comb begin
        ge_low   = ge & (~ge + MAX_HALF_WINDOW'(1));
        new_left = '0;
        for (int j = 0; j < MAX_HALF_WINDOW; j++) begin
            new_left = new_left | (ge_low[j] ? DIST_W'(j + 1) : '0);
        end
        if (ge == '0) begin
            new_left = DIST_NONE;
        end
    end

    assign p_valid[0]  = 1'b1;
    assign p_sample[0] = s_axis_tdata;
    assign p_left[0]   = new_left;
    assign p_right[0]  = DIST_NONE;

    // Cell j holds the sample of age j+1 after the shift; each cell compares
    // against the incoming count and passes its contents to the next one.
    for (genvar j = 0; j < MAX_HALF_WINDOW; j++) begin : g_cell
        swpf_cell #(
            .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
            .POS             (j)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_shift       (accept),
            .i_clear       (s_axis_tlast),
            .i_x           (s_axis_tdata),
            .i_prev_valid  (p_valid[j]),
            .i_prev_sample (p_sample[j]),
            .i_prev_left   (p_left[j]),
            .i_prev_right  (p_right[j]),
            .o_ge          (ge[j]),
            .o_valid       (p_valid[j+1]),
            .o_sample      (p_sample[j+1]),
            .o_left        (p_left[j+1]),
            .o_right       (p_right[j+1])
        );
    end

    // ------------------------------------------------------------------
    // Peak decision. A center survives when no count >= it lies within h
    // on either side. Normally only age h is due; on the last sample every
    // age up to h is. Survivors are at most one, so an AND-OR mux selects.
    // ------------------------------------------------------------------
    always_comb begin
        sel_sample = '0;
        sel_age    = '0;
        for (int a = 0; a <= MAX_HALF_WINDOW; a++) begin
            cand[a] = p_valid[a] && (p_left[a] > h) && (p_right[a] > h) &&
                      (s_axis_tlast ? (DIST_W'(a) <= h) : (DIST_W'(a) == h));
            sel_sample = sel_sample | ({SAMPLE_W{cand[a]}} & p_sample[a]);
            sel_age    = sel_age | (cand[a] ? AGE_W'(a) : '0);
        end
    end

    assign found    = (|cand) && (sel_sample > r_min_height);
    assign cnt_post = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_W'(1);
    assign ovf_post = r_ovf || (r_cnt == CNT_MAX);
    // channel index of the center; never above CHANNELS-1 since cnt_post <= CHANNELS
    assign idx      = (cnt_post > CNT_W'(sel_age))
                    ? cnt_post - CNT_W'(1) - CNT_W'(sel_age) : '0;
    assign push     = accept && found;

    always_comb begin
        res_data                      = '0;
        res_data[CH_W-1:0]            = CH_W'(idx);
        res_data[CH_W +: SAMPLE_W]    = sel_sample;
        res_data[CH_W + SAMPLE_W]     = ovf_post;
    end

    // ------------------------------------------------------------------
    // Channel counter, saturating; cleared after the last sample
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (accept) begin
            if (s_axis_tlast) begin
                r_cnt <= '0;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= cnt_post;
                r_ovf <= ovf_post;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid slot; input stalls only when both hold
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (push) begin
            if (r_out_valid && !m_axis_tready) begin
                r_skid_data <= res_data;
            end else begin
                r_out_data <= res_data;
            end
        end
    end

endmodule

`default_nettype wire

/* dv/tb_spectrum_window_peak_finder.sv */
`default_nettype none

module tb_spectrum_window_peak_finder;
    timeunit 1ns;
    timeprecision 1ps;

    import swpf_pkg::*;

    localparam int MAX_HW    = MAX_HALF_WINDOW_DEF;
    localparam int CHANNELS  = CHANNELS_DEF;
    localparam int WIN_D     = 2 * MAX_HW + 1;
    // output is registered and may wait in the skid slot; pad the settle wait generously
    localparam int SETTLE    = 8;
    localparam int MAX_PRINT = 40;

    // one decoded peak report
    typedef struct packed {
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] height;
        logic                ovf;
    } t_peak;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata  = '0;   // sample_count[31:0]
    logic                  s_axis_tlast  = 1'b0; // end_of_spectrum
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // peak_channel[11:0], peak_height[43:12], overflow[44], zero pad[47:45]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    spectrum_window_peak_finder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: shadow registers plus a copy of the sliding window.
    // Slot 0 holds the newest sample, slot k the one k channels older.
    // ---------------------------------------------------------------
    logic [HW_W-1:0]     cfg_half_window = HW_RESET;
    logic [SAMPLE_W-1:0] cfg_min_height  = MH_RESET;
    logic [SAMPLE_W-1:0] win_count [WIN_D];
    logic                win_filled[WIN_D];
    logic [CH_W:0]       chan_cnt;   // one bit wider: must hold CHANNELS itself
    logic                ovf_seen;

    t_peak expected_peaks[$];

    int  mismatch_count = 0;
    bit  idle_on        = 1'b1;   // sender gaps
    bit  stall_on       = 1'b1;   // receiver back-pressure
    int  stall_left     = 0;

    function automatic void clear_window();
        for (int k = 0; k < WIN_D; k++) begin
            win_count[k]  = '0;
            win_filled[k] = 1'b0;
        end
        chan_cnt = '0;
        ovf_seen = 1'b0;
    endfunction

    // Center at age c wins if it clears the threshold and beats every live
    // neighbor: all newer slots, and up to h older ones.
    function automatic bit is_local_max(input int c, input int h);
        logic [SAMPLE_W-1:0] v;
        if (!win_filled[c])
            return 1'b0;
        v = win_count[c];
        if (v <= cfg_min_height)
            return 1'b0;
        for (int k = 0; k < c; k++)
            if (win_filled[k] && win_count[k] >= v)
                return 1'b0;
        for (int k = c + 1; k <= c + h && k < WIN_D; k++)
            if (win_filled[k] && win_count[k] >= v)
                return 1'b0;
        return 1'b1;
    endfunction

    // Advance the window by one accepted sample and queue any peak it settles.
    function automatic void predict_peak(input logic [SAMPLE_W-1:0] cnt, input logic last);
        int            h;
        int            lowest;
        bit            found;
        logic [CH_W:0] idx;
        t_peak         p;
        h = (cfg_half_window > MAX_HW) ? MAX_HW : int'(cfg_half_window);
        for (int k = WIN_D - 1; k > 0; k--) begin
            win_count[k]  = win_count[k-1];
            win_filled[k] = win_filled[k-1];
        end
        win_count[0]  = cnt;
        win_filled[0] = 1'b1;

        // counter saturates; once it is pinned every later sample flags overflow
        if (chan_cnt >= CHANNELS)
            ovf_seen = 1'b1;
        else
            chan_cnt = chan_cnt + 1'b1;

        // normal step: only the center at age h is due; last sample: all pending
        lowest = last ? 0 : h;
        found  = 1'b0;
        for (int c = h; c >= lowest && !found; c--) begin
            if (is_local_max(c, h)) begin
                idx = (chan_cnt > c) ? chan_cnt - 1'b1 - c[CH_W:0] : '0;
                if (idx > CHANNELS - 1)
                    idx = (CH_W+1)'(CHANNELS - 1);
                p.channel = idx[CH_W-1:0];
                p.height  = win_count[c];
                p.ovf     = ovf_seen;
                expected_peaks = {expected_peaks, p};
                found = 1'b1;
            end
        end
        if (last)
            clear_window();
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINT)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    // ---------------------------------------------------------------
    // Receiver: back-pressure in random bursts of stalled cycles
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 7) == 0) begin
            stall_left    <= $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Result checker: every output transaction against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : check_peaks
        t_peak got;
        t_peak want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.channel = m_axis_tdata[CH_W-1:0];
            got.height  = m_axis_tdata[CH_W+SAMPLE_W-1:CH_W];
            got.ovf     = m_axis_tdata[CH_W+SAMPLE_W];
            if (expected_peaks.size() == 0) begin
                report_mismatch($sformatf("unexpected peak ch %0d height %0d ovf %0b",
                                          got.channel, got.height, got.ovf));
            end else begin
                want = expected_peaks.pop_front();
                if (got.channel !== want.channel)
                    report_mismatch($sformatf("peak_channel got %0d exp %0d",
                                              got.channel, want.channel));
                if (got.height !== want.height)
                    report_mismatch($sformatf("peak_height got %0d exp %0d (ch %0d)",
                                              got.height, want.height, want.channel));
                if (got.ovf !== want.ovf)
                    report_mismatch($sformatf("overflow got %0b exp %0b (ch %0d)",
                                              got.ovf, want.ovf, want.channel));
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // One sample transaction; may be preceded by a random idle burst.
    task automatic send_sample(input logic [SAMPLE_W-1:0] cnt, input logic last);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= cnt;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        predict_peak(cnt, last);
    endtask

    // Stop sending and hold until every queued peak has been seen, then let the
    // pipe settle so a trailing no-result sample is finished too.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_peaks.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Registers are only touched with the block idle (caller drains first).
    task automatic write_reg(input t_cfg_addr addr, input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (addr)
            CFG_HALF_WINDOW: cfg_half_window = value[HW_W-1:0];
            CFG_MIN_HEIGHT:  cfg_min_height  = value;
            default: ;
        endcase
    endtask

    // half_window write with junk above the field, which the block must drop, then min_height
    task automatic set_window(input int hw, input logic [SAMPLE_W-1:0] mh);
        logic [CFG_DATA_W-1:0] v;
        v            = $urandom();
        v[HW_W-1:0]  = hw[HW_W-1:0];
        write_reg(CFG_HALF_WINDOW, v);
        write_reg(CFG_MIN_HEIGHT, mh);
    endtask

    task automatic send_run(input logic [SAMPLE_W-1:0] counts[$]);
        foreach (counts[i])
            send_sample(counts[i], i == counts.size() - 1);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset values (23 / 20): count at the threshold is not a peak, one above is;
    // the spectrum is shorter than the window so the peak resolves on the last one.
    task automatic test_reset_defaults();
        send_run('{32'd5, 32'd21, 32'd3, 32'd20, 32'd0});
        wait_drained();
    endtask

    // Zero half window: every count above min_height reports on its own.
    task automatic test_zero_window();
        set_window(0, 32'd0);
        send_run('{32'd0, 32'd1, 32'd1, 32'hFFFF_FFFF});
        wait_drained();
    endtask

    // Widest window and threshold extremes, plus a one-channel spectrum.
    task automatic test_extremes();
        set_window(MAX_HW, 32'hFFFF_FFFF);
        send_run('{32'hFFFF_FFFF});
        wait_drained();
        set_window(MAX_HW, 32'hFFFF_FFFE);
        send_run('{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd7});
        wait_drained();
    endtask

    // Narrow window: ties never qualify, peak on the last channel still found.
    task automatic test_ties_and_edges();
        set_window(1, 32'd0);
        send_run('{32'd3, 32'd5, 32'd5, 32'd2, 32'd9, 32'd1, 32'd4});
        wait_drained();
    endtask

    // Spectrum past CHANNELS: index pins, overflow rides on later reports.
    task automatic test_overflow();
        int len;
        logic [SAMPLE_W-1:0] cnt;
        len = CHANNELS + 48;
        set_window(4, 32'd100);
        for (int i = 0; i < len; i++) begin
            if (i == CHANNELS + 20)
                cnt = 32'hFFFF_FFFF;
            else if ($urandom_range(0, 49) == 0)
                cnt = $urandom_range(101, 32'hFFFF_FFFF);
            else
                cnt = $urandom_range(0, 100);
            send_sample(cnt, i == len - 1);
        end
        wait_drained();
    endtask

    // Random spectra with content shaped to produce peaks: a noise floor with
    // sparse spikes, fully random counts, or a near-flat plateau.
    task automatic send_random_spectrum(input int len);
        int mode;
        logic [SAMPLE_W-1:0] cnt;
        logic [SAMPLE_W-1:0] prev;
        mode = $urandom_range(0, 9);
        prev = '0;
        for (int i = 0; i < len; i++) begin
            if (i == len / 2 && $urandom_range(0, 9) == 0)
                wait_drained();
            if (mode < 7) begin
                case ($urandom_range(0, 19))
                    0, 1:    cnt = $urandom() | 32'h100;
                    2:       cnt = prev;
                    default: cnt = $urandom_range(0, 63);
                endcase
            end else if (mode < 9) begin
                cnt = $urandom();
            end else begin
                cnt = $urandom_range(0, 3);
            end
            prev = cnt;
            send_sample(cnt, i == len - 1);
        end
    endtask

    task automatic test_random_spectra();
        int hw;
        int len;
        int sent;
        logic [SAMPLE_W-1:0] mh;
        for (int phase = 0; phase < 12; phase++) begin
            // final phases run at full rate on both sides
            idle_on  = (phase < 9);
            stall_on = (phase < 9);
            case (phase)
                0:       hw = 1;
                1:       hw = MAX_HW;
                2:       hw = 0;
                default: hw = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_HW)
                                                          : $urandom_range(1, 8);
            endcase
            case ($urandom_range(0, 7))
                0:       mh = 32'd0;
                1:       mh = 32'hFFFF_FFFF;
                2:       mh = $urandom();
                3:       mh = MH_RESET;
                default: mh = $urandom_range(0, 80);
            endcase
            set_window(hw, mh);
            sent = 0;
            while (sent < 125) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4)
                                                  : $urandom_range(5, 120);
                send_random_spectrum(len);
                sent += len;
            end
            wait_drained();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        clear_window();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_zero_window();
        test_extremes();
        test_ties_and_edges();
        test_overflow();
        test_random_spectra();

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_peaks.size() == 0) begin
            $display("tb_spectrum_window_peak_finder: PASS");
        end else begin
            $display("tb_spectrum_window_peak_finder: FAIL");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #5_000_000;
        $display("tb_spectrum_window_peak_finder: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/swpf_pkg.sv
rtl/core/swpf_cell.sv
rtl/core/spectrum_window_peak_finder.sv
dv/tb_spectrum_window_peak_finder.sv
